// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clock, off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DC2D_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DC2D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dc2d_pkg.sv =====
// ---------------------------------------------------------------------------
// dc2d_pkg
// shared types, codes and helpers of the direct 2-d convolution engine
// ---------------------------------------------------------------------------
package dc2d_pkg;

   localparam int DEF_MAX_IN_CH  = 16;
   localparam int DEF_MAX_OUT_CH = 16;
   localparam int DEF_MAX_IMG_H  = 32;
   localparam int DEF_MAX_IMG_W  = 32;
   localparam int DEF_KER_H      = 3;
   localparam int DEF_KER_W      = 3;

   localparam int ACC_W        = 48;
   localparam int CSR_AW       = 5;
   localparam int DRAIN_CYCLES = 2;

   typedef enum logic [1:0] {
      CMD_WEIGHT  = 2'd0,
      CMD_BIAS    = 2'd1,
      CMD_PIXEL   = 2'd2,
      CMD_COMPUTE = 2'd3
   } req_code_type;

   localparam logic [2:0] REG_STRIDE_ROWS  = 3'd0;
   localparam logic [2:0] REG_STRIDE_COLS  = 3'd1;
   localparam logic [2:0] REG_PAD_ROWS     = 3'd2;
   localparam logic [2:0] REG_PAD_COLS     = 3'd3;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd5;
   localparam logic [2:0] REG_CHANNELS     = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [3:0] stride_rows;
      logic [3:0] stride_cols;
      logic [2:0] pad_rows;
      logic [2:0] pad_cols;
      logic [5:0] image_height;
      logic [5:0] image_width;
      logic [4:0] channels_in_use;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      stride_rows:     4'd1,
      stride_cols:     4'd1,
      pad_rows:        3'd0,
      pad_cols:        3'd0,
      image_height:    6'd32,
      image_width:     6'd32,
      channels_in_use: 5'd16
   };

   typedef struct packed {
      logic accept;
      logic issue;
      logic load_out;
      logic err;
   } dp_cmd_type;

   typedef struct packed {
      logic nch_zero;
      logic last_tap;
   } dp_status_type;

   function automatic int idx_w(int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic logic signed [15:0] sat_q88(logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== src/dc2d_if.sv =====
// ---------------------------------------------------------------------------
// dc2d request and result channels
// valid/ready channels carrying the request and result payloads
// ---------------------------------------------------------------------------
interface dc2d_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [3:0]         out_chan;
   logic [3:0]         in_chan;
   logic [5:0]         row;
   logic [5:0]         col;
   logic [2:0]         tap_row;
   logic [2:0]         tap_col;
   logic signed [31:0] value;

   modport source (
      output valid, cmd, out_chan, in_chan, row, col, tap_row, tap_col, value,
      input  ready
   );
   modport sink (
      input  valid, cmd, out_chan, in_chan, row, col, tap_row, tap_col, value,
      output ready
   );
endinterface

interface dc2d_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_value;
   logic               index_error;

   modport source (
      output valid, out_value, index_error,
      input  ready
   );
   modport sink (
      input  valid, out_value, index_error,
      output ready
   );
endinterface

// ===== src/dc2d_csr.sv =====
// ---------------------------------------------------------------------------
// dc2d_csr
// apb-style register file holding the convolution geometry
// ---------------------------------------------------------------------------
module dc2d_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [dc2d_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output dc2d_pkg::cfg_type            cfg
);

   dc2d_pkg::cfg_type cfg_ff;
   dc2d_pkg::cfg_type cfg_in;
   logic [2:0]        reg_idx;
   logic              wr;

   assign reg_idx = paddr[dc2d_pkg::CSR_AW-1:2];
   assign wr      = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (reg_idx)
            dc2d_pkg::REG_STRIDE_ROWS:  cfg_in.stride_rows     = pwdata[3:0];
            dc2d_pkg::REG_STRIDE_COLS:  cfg_in.stride_cols     = pwdata[3:0];
            dc2d_pkg::REG_PAD_ROWS:     cfg_in.pad_rows        = pwdata[2:0];
            dc2d_pkg::REG_PAD_COLS:     cfg_in.pad_cols        = pwdata[2:0];
            dc2d_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height    = pwdata[5:0];
            dc2d_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width     = pwdata[5:0];
            dc2d_pkg::REG_CHANNELS:     cfg_in.channels_in_use = pwdata[4:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         dc2d_pkg::REG_STRIDE_ROWS:  prdata = 32'(cfg_ff.stride_rows);
         dc2d_pkg::REG_STRIDE_COLS:  prdata = 32'(cfg_ff.stride_cols);
         dc2d_pkg::REG_PAD_ROWS:     prdata = 32'(cfg_ff.pad_rows);
         dc2d_pkg::REG_PAD_COLS:     prdata = 32'(cfg_ff.pad_cols);
         dc2d_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_ff.image_height);
         dc2d_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_ff.image_width);
         dc2d_pkg::REG_CHANNELS:     prdata = 32'(cfg_ff.channels_in_use);
         default:                    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= dc2d_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/dc2d_ctrl.sv =====
// ---------------------------------------------------------------------------
// dc2d_ctrl
// request sequencer: accepts requests, steps the tap loop, drains, delivers
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dc2d_ctrl #(
   parameter int MAX_OUT_CH = dc2d_pkg::DEF_MAX_OUT_CH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_cmd,
   input  logic [3:0]                req_out_chan,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  dc2d_pkg::dp_status_type   status,
   output dc2d_pkg::dp_cmd_type      cmd
);

   dc2d_pkg::state_type state_ff;
   dc2d_pkg::state_type state_in;
   logic [1:0]          drain_ff;
   logic [1:0]          drain_in;
   logic                err_ff;
   logic                err_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;
   logic                is_compute;
   logic                oc_bad;

   assign req_ready  = (state_ff == dc2d_pkg::ST_IDLE);
   assign accept     = req_valid & req_ready;
   assign is_compute = (req_cmd == dc2d_pkg::CMD_COMPUTE);
   assign oc_bad     = (32'(req_out_chan) >= MAX_OUT_CH);
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      drain_in     = drain_ff;
      err_in       = err_ff;
      cmd.accept   = accept;
      cmd.issue    = 1'b0;
      cmd.load_out = 1'b0;
      cmd.err      = err_ff;
      unique case (state_ff)
         dc2d_pkg::ST_IDLE: begin
            if (accept && is_compute) begin
               err_in   = oc_bad;
               state_in = oc_bad ? dc2d_pkg::ST_FINISH : dc2d_pkg::ST_RUN;
            end
         end
         dc2d_pkg::ST_RUN: begin
            drain_in = 2'd0;
            if (status.nch_zero) begin
               state_in = dc2d_pkg::ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
               if (status.last_tap) begin
                  state_in = dc2d_pkg::ST_DRAIN;
               end
            end
         end
         dc2d_pkg::ST_DRAIN: begin
            if (drain_ff == 2'(dc2d_pkg::DRAIN_CYCLES - 1)) begin
               state_in = dc2d_pkg::ST_FINISH;
            end else begin
               drain_in = drain_ff + 2'd1;
            end
         end
         dc2d_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = dc2d_pkg::ST_IDLE;
            end
         end
         default: state_in = dc2d_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dc2d_pkg::ST_IDLE;
         drain_ff     <= 2'd0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DC2D_ASSERT_NEXT(a_last_tap_drains, cmd.issue && status.last_tap, state_ff == dc2d_pkg::ST_DRAIN, "last tap did not lead to drain")
   `DC2D_ASSERT_IMPLY(a_load_slot_free, cmd.load_out, !rsp_valid_ff || rsp_ready, "result loaded over a pending one")
   `DC2D_ASSERT_NEXT(a_compute_starts, accept && is_compute, state_ff == dc2d_pkg::ST_RUN || state_ff == dc2d_pkg::ST_FINISH, "compute request not started")
   `DC2D_ASSERT_IMPLY(a_result_from_finish, $rose(rsp_valid_ff), $past(state_ff == dc2d_pkg::ST_FINISH), "result raised outside finish")

endmodule

// ===== src/dc2d_datapath.sv =====
// ---------------------------------------------------------------------------
// dc2d_datapath
// image, weight and bias stores, tap address generation and the mac pipeline
// ---------------------------------------------------------------------------
module dc2d_datapath #(
   parameter int MAX_IN_CH  = dc2d_pkg::DEF_MAX_IN_CH,
   parameter int MAX_OUT_CH = dc2d_pkg::DEF_MAX_OUT_CH,
   parameter int MAX_IMG_H  = dc2d_pkg::DEF_MAX_IMG_H,
   parameter int MAX_IMG_W  = dc2d_pkg::DEF_MAX_IMG_W,
   parameter int KER_H      = dc2d_pkg::DEF_KER_H,
   parameter int KER_W      = dc2d_pkg::DEF_KER_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dc2d_pkg::cfg_type        cfg,
   input  dc2d_pkg::dp_cmd_type     cmd,
   output dc2d_pkg::dp_status_type  status,
   input  logic [1:0]               req_cmd,
   input  logic [3:0]               req_out_chan,
   input  logic [3:0]               req_in_chan,
   input  logic [5:0]               req_row,
   input  logic [5:0]               req_col,
   input  logic [2:0]               req_tap_row,
   input  logic [2:0]               req_tap_col,
   input  logic signed [31:0]       req_value,
   output logic signed [31:0]       out_value,
   output logic                     index_error
);

   localparam int ICW        = dc2d_pkg::idx_w(MAX_IN_CH);
   localparam int OCW        = dc2d_pkg::idx_w(MAX_OUT_CH);
   localparam int HW         = dc2d_pkg::idx_w(MAX_IMG_H);
   localparam int WW         = dc2d_pkg::idx_w(MAX_IMG_W);
   localparam int KHW        = dc2d_pkg::idx_w(KER_H);
   localparam int KWW        = dc2d_pkg::idx_w(KER_W);
   localparam int IMG_AW     = ICW + HW + WW;
   localparam int WGT_AW     = OCW + ICW + KHW + KWW;
   localparam int IMG_DEPTH  = 1 << IMG_AW;
   localparam int WGT_DEPTH  = 1 << WGT_AW;
   localparam int BIAS_DEPTH = 1 << OCW;
   localparam int NCH_W      = $clog2(MAX_IN_CH + 1);
   localparam int HD_W       = $clog2(MAX_IMG_H + 1);
   localparam int WD_W       = $clog2(MAX_IMG_W + 1);
   localparam int AW         = dc2d_pkg::ACC_W;

   logic signed [15:0] img_mem  [IMG_DEPTH];
   logic signed [15:0] wgt_mem  [WGT_DEPTH];
   logic signed [31:0] bias_mem [BIAS_DEPTH];

   logic [7:0]         oc_ext;
   logic [7:0]         ic_ext;
   logic [7:0]         row_ext;
   logic [7:0]         col_ext;
   logic [7:0]         tr_ext;
   logic [7:0]         tc_ext;
   logic signed [15:0] sat_val;
   logic               start;
   logic               img_we;
   logic               wgt_we;
   logic               bias_we;
   logic [IMG_AW-1:0]  img_wa;
   logic [WGT_AW-1:0]  wgt_wa;
   logic [IMG_AW-1:0]  img_ra;
   logic [WGT_AW-1:0]  wgt_ra;

   logic [OCW-1:0]     oc_ff;
   logic signed [11:0] base_r_ff;
   logic signed [11:0] base_c_ff;
   logic signed [11:0] base_r_in;
   logic signed [11:0] base_c_in;
   logic [HD_W-1:0]    h_ff;
   logic [WD_W-1:0]    w_ff;
   logic [NCH_W-1:0]   nch_ff;
   logic [HD_W-1:0]    h_in;
   logic [WD_W-1:0]    w_in;
   logic [NCH_W-1:0]   nch_in;

   logic [ICW-1:0]     c_ff;
   logic [KHW-1:0]     a_ff;
   logic [KWW-1:0]     b_ff;
   logic               a_last;
   logic               b_last;
   logic               c_last;

   logic signed [11:0] ih;
   logic signed [11:0] iw;
   logic               in_bounds;

   logic signed [15:0] img_rd_ff;
   logic signed [15:0] wgt_rd_ff;
   logic signed [31:0] bias_rd_ff;
   logic               v1_ff;
   logic               v2_ff;
   logic signed [31:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] sum;
   logic               fits;
   logic signed [31:0] sat_sum;
   logic signed [31:0] out_value_ff;
   logic               index_error_ff;

   assign oc_ext  = 8'(req_out_chan);
   assign ic_ext  = 8'(req_in_chan);
   assign row_ext = 8'(req_row);
   assign col_ext = 8'(req_col);
   assign tr_ext  = 8'(req_tap_row);
   assign tc_ext  = 8'(req_tap_col);
   assign sat_val = dc2d_pkg::sat_q88(req_value);

   assign start   = cmd.accept && (req_cmd == dc2d_pkg::CMD_COMPUTE);
   assign wgt_we  = cmd.accept && (req_cmd == dc2d_pkg::CMD_WEIGHT)
                    && (32'(req_out_chan) < MAX_OUT_CH) && (32'(req_in_chan) < MAX_IN_CH)
                    && (32'(req_tap_row) < KER_H) && (32'(req_tap_col) < KER_W);
   assign bias_we = cmd.accept && (req_cmd == dc2d_pkg::CMD_BIAS)
                    && (32'(req_out_chan) < MAX_OUT_CH);
   assign img_we  = cmd.accept && (req_cmd == dc2d_pkg::CMD_PIXEL)
                    && (32'(req_in_chan) < MAX_IN_CH) && (32'(req_row) < MAX_IMG_H)
                    && (32'(req_col) < MAX_IMG_W);

   assign img_wa = {ic_ext[ICW-1:0], row_ext[HW-1:0], col_ext[WW-1:0]};
   assign wgt_wa = {oc_ext[OCW-1:0], ic_ext[ICW-1:0], tr_ext[KHW-1:0], tc_ext[KWW-1:0]};

   // output position to top-left input position
   assign base_r_in = $signed(12'(10'(req_row) * 10'(cfg.stride_rows)))
                      - $signed(12'(cfg.pad_rows));
   assign base_c_in = $signed(12'(10'(req_col) * 10'(cfg.stride_cols)))
                      - $signed(12'(cfg.pad_cols));
   assign h_in   = (32'(cfg.image_height) > MAX_IMG_H) ? HD_W'(MAX_IMG_H)
                                                       : HD_W'(cfg.image_height);
   assign w_in   = (32'(cfg.image_width) > MAX_IMG_W) ? WD_W'(MAX_IMG_W)
                                                      : WD_W'(cfg.image_width);
   assign nch_in = (32'(cfg.channels_in_use) > MAX_IN_CH) ? NCH_W'(MAX_IN_CH)
                                                          : NCH_W'(cfg.channels_in_use);

   assign a_last = (a_ff == KHW'(KER_H - 1));
   assign b_last = (b_ff == KWW'(KER_W - 1));
   assign c_last = (NCH_W'(c_ff) == nch_ff - NCH_W'(1));

   assign status.nch_zero = (nch_ff == '0);
   assign status.last_tap = c_last && a_last && b_last;

   assign ih        = base_r_ff + $signed(12'(a_ff));
   assign iw        = base_c_ff + $signed(12'(b_ff));
   assign in_bounds = !ih[11] && (ih[10:0] < 11'(h_ff))
                      && !iw[11] && (iw[10:0] < 11'(w_ff));

   assign img_ra = {c_ff, ih[HW-1:0], iw[WW-1:0]};
   assign wgt_ra = {oc_ff, c_ff, a_ff, b_ff};

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_wa] <= sat_val;
      end
      img_rd_ff <= img_mem[img_ra];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem[wgt_wa] <= sat_val;
      end
      wgt_rd_ff <= wgt_mem[wgt_ra];
   end

   always_ff @(posedge clock) begin
      if (bias_we) begin
         bias_mem[oc_ext[OCW-1:0]] <= req_value;
      end
      if (start) begin
         bias_rd_ff <= bias_mem[oc_ext[OCW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         oc_ff     <= oc_ext[OCW-1:0];
         base_r_ff <= base_r_in;
         base_c_ff <= base_c_in;
         h_ff      <= h_in;
         w_ff      <= w_in;
         nch_ff    <= nch_in;
      end
   end

   // tap loop: column, then row, then input channel
   always_ff @(posedge clock) begin
      if (start) begin
         c_ff <= '0;
         a_ff <= '0;
         b_ff <= '0;
      end else if (cmd.issue) begin
         if (b_last) begin
            b_ff <= '0;
            if (a_last) begin
               a_ff <= '0;
               c_ff <= c_ff + ICW'(1);
            end else begin
               a_ff <= a_ff + KHW'(1);
            end
         end else begin
            b_ff <= b_ff + KWW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue && in_bounds;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= img_rd_ff * wgt_rd_ff;
      if (start) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + {{(AW - 32){prod_ff[31]}}, prod_ff};
      end
   end

   assign sum     = acc_ff + {{(AW - 32){bias_rd_ff[31]}}, bias_rd_ff};
   assign fits    = (sum[AW-1:31] == '0) || (sum[AW-1:31] == '1);
   assign sat_sum = fits ? sum[31:0] : (sum[AW-1] ? 32'sh80000000 : 32'sh7fffffff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_value_ff   <= cmd.err ? 32'sd0 : sat_sum;
         index_error_ff <= cmd.err;
      end
   end

   assign out_value   = out_value_ff;
   assign index_error = index_error_ff;

endmodule

// ===== src/direct_conv2d_engine.sv =====
// a write request is taken while the engine is idle and gives no result
// a compute request steps N*KER_H*KER_W taps (none when N is 0), drains the mac pipeline,
//   then loads its result; N = channels in use after clamping; index errors skip taps and drain
// one write per cycle while idle; a new request waits until the last compute has loaded
//   its result, which itself waits while an earlier result is still unaccepted
// reset: synchronous, active high; control, config and valid registers to defaults, stores left unwritten
// ---------------------------------------------------------------------------
// direct_conv2d_engine
// direct 2-d convolution engine: loads weights, biases and one image, then
// computes single saturated q16.16 outputs on request
// ---------------------------------------------------------------------------
module direct_conv2d_engine #(
   parameter int MAX_IN_CH  = dc2d_pkg::DEF_MAX_IN_CH,
   parameter int MAX_OUT_CH = dc2d_pkg::DEF_MAX_OUT_CH,
   parameter int MAX_IMG_H  = dc2d_pkg::DEF_MAX_IMG_H,
   parameter int MAX_IMG_W  = dc2d_pkg::DEF_MAX_IMG_W,
   parameter int KER_H      = dc2d_pkg::DEF_KER_H,
   parameter int KER_W      = dc2d_pkg::DEF_KER_W
) (
   input  logic                         clock,
   input  logic                         reset,
   dc2d_req_if.sink                     req,
   dc2d_rsp_if.source                   rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [dc2d_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   dc2d_pkg::cfg_type       cfg;
   dc2d_pkg::dp_cmd_type    dp_cmd;
   dc2d_pkg::dp_status_type dp_status;

   dc2d_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dc2d_ctrl #(
      .MAX_OUT_CH (MAX_OUT_CH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_ready    (req.ready),
      .req_cmd      (req.cmd),
      .req_out_chan (req.out_chan),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .status       (dp_status),
      .cmd          (dp_cmd)
   );

   dc2d_datapath #(
      .MAX_IN_CH  (MAX_IN_CH),
      .MAX_OUT_CH (MAX_OUT_CH),
      .MAX_IMG_H  (MAX_IMG_H),
      .MAX_IMG_W  (MAX_IMG_W),
      .KER_H      (KER_H),
      .KER_W      (KER_W)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .req_cmd      (req.cmd),
      .req_out_chan (req.out_chan),
      .req_in_chan  (req.in_chan),
      .req_row      (req.row),
      .req_col      (req.col),
      .req_tap_row  (req.tap_row),
      .req_tap_col  (req.tap_col),
      .req_value    (req.value),
      .out_value    (rsp.out_value),
      .index_error  (rsp.index_error)
   );

endmodule
